// File: design/assert_macros.svh
// assertion helpers shared by the checker files
// every macro samples on i_clk and is held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MET_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("met assertion failed");

// next-cycle implication
`define MET_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("met assertion failed");

// implication after a fixed number of cycles
`define MET_ASSERT_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error("met assertion failed");

`endif

// File: design/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// Shared types and constants of the multi-channel event timer.
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int OPCODE_W         = 3;
    localparam int CHANNEL_W        = 4;
    localparam int TIMEOUT_W        = 32;
    localparam int MASK_W           = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK  = 3'd0,
        OP_SET   = 3'd1,
        OP_POST  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_PEND  = 3'd4,
        OP_TEST  = 3'd5
    } t_opcode;

    // one registered request as it goes to the lanes and the result stage
    typedef struct packed {
        t_opcode                opcode;
        logic [CHANNEL_W-1:0]   channel;
        logic                   reload_flag;
        logic [TIMEOUT_W-1:0]   timeout_ticks;
    } t_cmd;

endpackage

// File: design/met_channel.sv
// ----------------------------------------------------------------------------
// met_channel
// One timer lane: period, tick count and reload flag, with its fire pulse.
// ----------------------------------------------------------------------------
module met_channel
    import met_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_exec,
    input  logic i_sel,
    input  t_cmd i_cmd,
    output logic o_fire
);

    logic [TIMEOUT_W-1:0] r_period;
    logic [TIMEOUT_W-1:0] n_period;
    logic [TIMEOUT_W-1:0] r_count;
    logic [TIMEOUT_W-1:0] n_count;
    logic                 r_reload;
    logic                 n_reload;
    logic [TIMEOUT_W-1:0] w_count_inc;
    logic                 w_armed;

    assign w_armed     = (r_period != '0);
    assign w_count_inc = r_count + 1'b1;

    always_comb begin
        n_period = r_period;
        n_count  = r_count;
        n_reload = r_reload;
        o_fire   = 1'b0;
        if (i_exec) begin
            case (i_cmd.opcode)
                OP_TICK: begin
                    if (w_armed) begin
                        if (w_count_inc >= r_period) begin
                            n_count = '0;
                            o_fire  = 1'b1;
                            // one-shot lanes disarm on expiry
                            if (!r_reload) begin
                                n_period = '0;
                            end
                        end else begin
                            n_count = w_count_inc;
                        end
                    end
                end
                OP_SET: begin
                    if (i_sel) begin
                        n_period = i_cmd.timeout_ticks;
                        n_count  = '0;
                        n_reload = i_cmd.reload_flag;
                        o_fire   = (i_cmd.timeout_ticks == '0);
                    end
                end
                OP_POST: begin
                    if (i_sel) begin
                        n_period = '0;
                        n_count  = '0;
                        n_reload = 1'b0;
                        o_fire   = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    if (i_sel) begin
                        n_period = '0;
                        n_count  = '0;
                        n_reload = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_count  <= '0;
            r_reload <= 1'b0;
        end else begin
            r_period <= n_period;
            r_count  <= n_count;
            r_reload <= n_reload;
        end
    end

endmodule

// File: design/met_result.sv
// ----------------------------------------------------------------------------
// met_result
// Pending and latched masks, and the registered result of each request.
// ----------------------------------------------------------------------------
module met_result
    import met_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_exec,
    input  t_cmd                    i_cmd,
    input  logic [NUM_CHANNELS-1:0] i_sel,
    input  logic [NUM_CHANNELS-1:0] i_fire,
    input  logic                    i_out_stall,
    output logic                    o_out_free,
    output logic                    o_out_valid,
    output logic [MASK_W-1:0]       o_pending_mask,
    output logic                    o_event_hit
);

    localparam int EXT_W = (NUM_CHANNELS > MASK_W) ? NUM_CHANNELS : MASK_W;

    logic [NUM_CHANNELS-1:0] r_pending;
    logic [NUM_CHANNELS-1:0] n_pending;
    logic [NUM_CHANNELS-1:0] r_latched;
    logic [NUM_CHANNELS-1:0] n_latched;
    logic                    r_out_valid;
    logic [MASK_W-1:0]       r_pending_mask;
    logic                    r_event_hit;
    logic [MASK_W-1:0]       n_pending_mask;
    logic                    n_event_hit;
    logic [EXT_W-1:0]        w_pending_ext;

    assign o_out_free     = !r_out_valid || !i_out_stall;
    assign w_pending_ext  = EXT_W'(r_pending);

    always_comb begin
        n_pending      = r_pending;
        n_latched      = r_latched;
        n_pending_mask = '0;
        n_event_hit    = 1'b0;
        if (i_exec) begin
            case (i_cmd.opcode)
                OP_PEND: begin
                    // only the low channels reach the mask output
                    n_pending_mask = w_pending_ext[MASK_W-1:0];
                    n_latched      = r_pending;
                    n_pending      = '0;
                end
                OP_TEST: begin
                    n_event_hit = |(r_latched & i_sel);
                end
                default: begin
                    n_pending = r_pending | i_fire;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_latched   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_latched <= n_latched;
            if (i_exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_exec) begin
            r_pending_mask <= n_pending_mask;
            r_event_hit    <= n_event_hit;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pending_mask = r_pending_mask;
    assign o_event_hit    = r_event_hit;

endmodule

// File: design/multi_channel_event_timer.sv
// ----------------------------------------------------------------------------
// multi_channel_event_timer
// Bank of event timers with a pending mask, one request per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
// - input channel: i_in_valid / o_in_stall with opcode, channel, reload flag
//   and timeout; a request is taken on a clock edge with valid high and
//   stall low
// - output channel: o_out_valid / i_out_stall with pending_mask and
//   event_hit; every request gives exactly one result
// - an accepted request sits in the request register, which feeds the timer
//   lanes and result logic; these load the result register when it is not
//   holding a stalled result
// - one request per cycle unless the receiver stalls; all lanes count in
//   parallel on a tick; set, post, clear touch one lane, test one latched bit
// - when the receiver stalls, the result register holds its value; the
//   request register takes one more request if empty, then o_in_stall rises
// - synchronous reset disarms every lane, clears counts, reload flags and
//   both masks, and empties the request and result registers
// ----------------------------------------------------------------------------
module multi_channel_event_timer
    import met_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [OPCODE_W-1:0]  i_opcode,
    input  logic [CHANNEL_W-1:0] i_channel,
    input  logic                 i_reload_flag,
    input  logic [TIMEOUT_W-1:0] i_timeout_ticks,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [MASK_W-1:0]    o_pending_mask,
    output logic                 o_event_hit
);

    localparam int SEL_W = CHANNEL_W + 1;

    logic                    r_in_valid;
    t_cmd                    r_cmd;
    logic                    w_out_free;
    logic                    w_exec;
    logic [NUM_CHANNELS-1:0] w_sel;
    logic [NUM_CHANNELS-1:0] w_fire;

    assign w_exec     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_cmd.opcode        <= t_opcode'(i_opcode);
            r_cmd.channel       <= i_channel;
            r_cmd.reload_flag   <= i_reload_flag;
            r_cmd.timeout_ticks <= i_timeout_ticks;
        end
    end

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
        // channels at or above the lane count match no lane
        assign w_sel[g] = ({1'b0, r_cmd.channel} == SEL_W'(g));

        met_channel u_channel (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_exec  (w_exec),
            .i_sel   (w_sel[g]),
            .i_cmd   (r_cmd),
            .o_fire  (w_fire[g])
        );
    end

    met_result #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_exec         (w_exec),
        .i_cmd          (r_cmd),
        .i_sel          (w_sel),
        .i_fire         (w_fire),
        .i_out_stall    (i_out_stall),
        .o_out_free     (w_out_free),
        .o_out_valid    (o_out_valid),
        .o_pending_mask (o_pending_mask),
        .o_event_hit    (o_event_hit)
    );

endmodule

// File: design/met_checker.sv
// ----------------------------------------------------------------------------
// met_checker
// Port-level checks of the event timer, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module met_checker
    import met_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic [OPCODE_W-1:0]  i_opcode,
    input logic [CHANNEL_W-1:0] i_channel,
    input logic                 i_reload_flag,
    input logic [TIMEOUT_W-1:0] i_timeout_ticks,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [MASK_W-1:0]    o_pending_mask,
    input logic                 o_event_hit
);

    logic w_in_accept;

    assign w_in_accept = i_in_valid && !o_in_stall;

    // a result carries a mask or a hit, never both
    `MET_ASSERT_NOW(a_one_field, o_out_valid, !(o_event_hit && (o_pending_mask != '0)))

    // input backs up only behind a stalled, full result register
    `MET_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // an accepted request is followed by a valid result
    `MET_ASSERT_DELAY(a_latency, w_in_accept, 2, o_out_valid)

    // a stalled result holds
    `MET_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_pending_mask) && $stable(o_event_hit))

endmodule

bind multi_channel_event_timer met_checker u_met_checker (.*);
